>>> rtl/fan_pwm_mode_controller_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the fan PWM mode controller
// Shared helpers for concurrent checks, clocked on the rising edge with a
// synchronous reset as the disable condition.
// ----------------------------------------------------------------------------
`ifndef FAN_PWM_MODE_CONTROLLER_ASSERT_SVH
`define FAN_PWM_MODE_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define FPMC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FPMC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/fpmc_pkg.sv
// ----------------------------------------------------------------------------
// fpmc_pkg
// Types, codes, constants and lookup functions of the fan PWM mode controller.
// ----------------------------------------------------------------------------
package fpmc_pkg;

   localparam int PERIOD_W  = 16;
   localparam int FACTOR_W  = 7;
   localparam int LEVEL_W   = 4;
   localparam int PROD_W    = PERIOD_W + FACTOR_W;
   localparam int RECIP_W   = 24;
   localparam int RECIP_SH  = 30;
   localparam int FULL_W    = PROD_W + RECIP_W;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd400;
   // ceil(2^30 / 100): exact divide by 100 for products below 2^23
   localparam logic [RECIP_W-1:0]  RECIP_MUL    = 24'd10737419;

   localparam logic [1:0] TYPE_BYTE  = 2'd0;
   localparam logic [1:0] TYPE_KEY   = 2'd1;
   localparam logic [1:0] TYPE_LIGHT = 2'd2;

   localparam logic [1:0] DIR_FWD  = 2'd0;
   localparam logic [1:0] DIR_REV  = 2'd1;
   localparam logic [1:0] DIR_STOP = 2'd2;

   localparam logic [1:0] ACT_KEEP = 2'd0;
   localparam logic [1:0] ACT_FWD  = 2'd1;
   localparam logic [1:0] ACT_REV  = 2'd2;
   localparam logic [1:0] ACT_STOP = 2'd3;

   localparam logic [2:0] BAND_NONE = 3'd4;

   localparam logic [7:0] CHAR_F_UP   = 8'h46;
   localparam logic [7:0] CHAR_F_LO   = 8'h66;
   localparam logic [7:0] CHAR_R_UP   = 8'h52;
   localparam logic [7:0] CHAR_R_LO   = 8'h72;
   localparam logic [7:0] CHAR_S_UP   = 8'h53;
   localparam logic [7:0] CHAR_S_LO   = 8'h73;
   localparam logic [7:0] DIGIT_LO    = 8'd49;
   localparam logic [7:0] DIGIT_HI    = 8'd57;
   localparam logic [7:0] DIGIT_ZERO  = 8'd48;

   localparam logic [LEVEL_W-1:0]  LEVEL_FULL  = 4'd9;
   localparam logic [FACTOR_W-1:0] FACTOR_BASE = 7'd55;
   localparam logic [FACTOR_W-1:0] FACTOR_STEP = 7'd5;

   typedef struct packed {
      logic [1:0]          action;
      logic [FACTOR_W-1:0] factor;
      logic                echo_valid;
      logic [7:0]          echo_byte;
      logic                report_valid;
      logic [6:0]          report_percent;
      logic                light_mode;
      logic [1:0]          direction;
   } fpmc_ctl_type;

   function automatic logic [LEVEL_W-1:0] band_level(input logic [1:0] band);
      case (band)
         2'd0:    band_level = 4'd1;
         2'd1:    band_level = 4'd4;
         2'd2:    band_level = 4'd7;
         default: band_level = 4'd9;
      endcase
   endfunction

   function automatic logic [6:0] band_percent(input logic [1:0] band);
      case (band)
         2'd0:    band_percent = 7'd60;
         2'd1:    band_percent = 7'd75;
         2'd2:    band_percent = 7'd90;
         default: band_percent = 7'd100;
      endcase
   endfunction

endpackage

>>> rtl/fpmc_if.sv
// ----------------------------------------------------------------------------
// fpmc_if
// Valid/ready channels of the fan PWM mode controller: event in, result out.
// ----------------------------------------------------------------------------
interface fpmc_req_if import fpmc_pkg::*; ();
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [7:0]  rx_byte;
   logic [11:0] light_sample;

   modport source (output valid, req_type, rx_byte, light_sample, input ready);
   modport sink   (input valid, req_type, rx_byte, light_sample, output ready);
endinterface

interface fpmc_rsp_if import fpmc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [PERIOD_W-1:0] forward_compare;
   logic [PERIOD_W-1:0] reverse_compare;
   logic                echo_valid;
   logic [7:0]          echo_byte;
   logic                report_valid;
   logic [6:0]          report_percent;
   logic                light_mode;
   logic [1:0]          direction;

   modport source (output valid, forward_compare, reverse_compare, echo_valid, echo_byte,
                   report_valid, report_percent, light_mode, direction,
                   input ready);
   modport sink   (input valid, forward_compare, reverse_compare, echo_valid, echo_byte,
                   report_valid, report_percent, light_mode, direction,
                   output ready);
endinterface

>>> rtl/fan_pwm_mode_controller.sv
// ----------------------------------------------------------------------------
// fan_pwm_mode_controller
// Bidirectional fan PWM controller driven by command bytes, a mode key and
// light samples; computes both channel compare values per event.
// ----------------------------------------------------------------------------
//  channel   dir  contents
//  req_chan  in   req_type, rx_byte, light_sample
//  rsp_chan  out  compares, echo, report, light_mode, direction
//  csr_*     in   pwm_period write
//
//  One event per cycle unless rsp ready low stalls it; each result passes the
//  decode register, multiply register and result register in order.
//  The reciprocal multiply after the product register sets the path length.
//  Reset clears mode and compares, sets dir STOP, band NONE, period 400.
//  A waiting result with rsp ready low freezes every stage; req ready follows.
// ----------------------------------------------------------------------------
`include "fan_pwm_mode_controller_assert.svh"

module fan_pwm_mode_controller import fpmc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   fpmc_req_if.sink            req_chan,
   fpmc_rsp_if.source          rsp_chan,
   input  logic                csr_wr_en,
   input  logic [PERIOD_W-1:0] csr_wr_data
);

   logic [PERIOD_W-1:0] period_ff;
   logic                adv;
   logic                s1_valid, s2_valid;
   fpmc_ctl_type        s1_ctl, s2_ctl;
   logic [PERIOD_W-1:0] quotient;
   logic                rsp_valid_ff;
   logic [PERIOD_W-1:0] fwd_ff, fwd_in, rev_ff, rev_in;
   fpmc_ctl_type        out_ctl_ff;

   assign adv            = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
      end else if (csr_wr_en) begin
         period_ff <= csr_wr_data;
      end
   end

   fpmc_decode u_decode (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .req_valid    (req_chan.valid),
      .req_type     (req_chan.req_type),
      .rx_byte      (req_chan.rx_byte),
      .light_sample (req_chan.light_sample),
      .s1_valid     (s1_valid),
      .s1_ctl       (s1_ctl)
   );

   fpmc_scale u_scale (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .period   (period_ff),
      .s1_valid (s1_valid),
      .s1_ctl   (s1_ctl),
      .s2_valid (s2_valid),
      .s2_ctl   (s2_ctl),
      .quotient (quotient)
   );

   always_comb begin
      fwd_in = fwd_ff;
      rev_in = rev_ff;
      case (s2_ctl.action)
         ACT_FWD: begin
            fwd_in = quotient;
            rev_in = '0;
         end
         ACT_REV: begin
            fwd_in = '0;
            rev_in = quotient;
         end
         ACT_STOP: begin
            fwd_in = '0;
            rev_in = '0;
         end
         default: begin
         end
      endcase
   end

   // compare registers double as the duty state
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         fwd_ff       <= '0;
         rev_ff       <= '0;
      end else if (adv) begin
         rsp_valid_ff <= s2_valid;
         if (s2_valid) begin
            fwd_ff <= fwd_in;
            rev_ff <= rev_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv && s2_valid) begin
         out_ctl_ff <= s2_ctl;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.forward_compare = fwd_ff;
   assign rsp_chan.reverse_compare = rev_ff;
   assign rsp_chan.echo_valid      = out_ctl_ff.echo_valid;
   assign rsp_chan.echo_byte       = out_ctl_ff.echo_byte;
   assign rsp_chan.report_valid    = out_ctl_ff.report_valid;
   assign rsp_chan.report_percent  = out_ctl_ff.report_percent;
   assign rsp_chan.light_mode      = out_ctl_ff.light_mode;
   assign rsp_chan.direction       = out_ctl_ff.direction;

   `FPMC_ASSERT_SAME(a_echo_manual_only, clock, reset,
      rsp_valid_ff && out_ctl_ff.echo_valid, !out_ctl_ff.light_mode,
      "echo in light mode")
   `FPMC_ASSERT_SAME(a_report_light_only, clock, reset,
      rsp_valid_ff && out_ctl_ff.report_valid, out_ctl_ff.light_mode,
      "report in manual mode")
   `FPMC_ASSERT_SAME(a_one_channel_driven, clock, reset,
      rsp_valid_ff && (fwd_ff != '0), rev_ff == '0,
      "both PWM channels driven")

endmodule

>>> rtl/fpmc_decode.sv
// ----------------------------------------------------------------------------
// fpmc_decode
// Event decode, mode/direction/band state, and the first pipeline register.
// ----------------------------------------------------------------------------
`include "fan_pwm_mode_controller_assert.svh"

module fpmc_decode import fpmc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         adv,
   input  logic         req_valid,
   input  logic [1:0]   req_type,
   input  logic [7:0]   rx_byte,
   input  logic [11:0]  light_sample,
   output logic         s1_valid,
   output fpmc_ctl_type s1_ctl
);

   logic         mode_ff, mode_in;
   logic [1:0]   dir_ff, dir_in;
   logic [2:0]   band_ff, band_in;
   logic         s1_valid_ff;
   fpmc_ctl_type s1_ctl_ff, ctl_in;
   logic         accept;
   logic         is_digit, is_f, is_r, is_s;
   logic [LEVEL_W-1:0] level;
   logic [LEVEL_W-1:0] digit_level;
   logic [1:0]   band;

   assign accept      = req_valid && adv;
   assign is_digit    = (rx_byte >= DIGIT_LO) && (rx_byte <= DIGIT_HI);
   assign is_f        = (rx_byte == CHAR_F_UP) || (rx_byte == CHAR_F_LO);
   assign is_r        = (rx_byte == CHAR_R_UP) || (rx_byte == CHAR_R_LO);
   assign is_s        = (rx_byte == CHAR_S_UP) || (rx_byte == CHAR_S_LO);
   assign digit_level = LEVEL_W'(rx_byte - DIGIT_ZERO);
   assign band        = light_sample[11:10];

   always_comb begin
      mode_in = mode_ff;
      dir_in  = dir_ff;
      band_in = band_ff;
      level   = LEVEL_FULL;
      ctl_in  = '0;
      ctl_in.action = ACT_KEEP;
      case (req_type)
         TYPE_BYTE: begin
            if (!mode_ff) begin
               ctl_in.echo_valid = 1'b1;
               ctl_in.echo_byte  = rx_byte;
               case (dir_ff)
                  DIR_FWD: begin
                     if (is_digit) begin
                        ctl_in.action = ACT_FWD;
                        level         = digit_level;
                     end else if (is_s) begin
                        ctl_in.action = ACT_STOP;
                        dir_in        = DIR_STOP;
                     end else if (is_r) begin
                        ctl_in.action = ACT_REV;
                        dir_in        = DIR_REV;
                     end
                  end
                  DIR_REV: begin
                     if (is_digit) begin
                        ctl_in.action = ACT_REV;
                        level         = digit_level;
                     end else if (is_s) begin
                        ctl_in.action = ACT_STOP;
                        dir_in        = DIR_STOP;
                     end else if (is_f) begin
                        ctl_in.action = ACT_FWD;
                        dir_in        = DIR_FWD;
                     end
                  end
                  default: begin
                     if (is_f) begin
                        ctl_in.action = ACT_FWD;
                        dir_in        = DIR_FWD;
                     end else if (is_r) begin
                        ctl_in.action = ACT_REV;
                        dir_in        = DIR_REV;
                     end
                  end
               endcase
            end
         end
         TYPE_KEY: begin
            if (!mode_ff) begin
               mode_in = 1'b1;
            end else begin
               mode_in       = 1'b0;
               dir_in        = DIR_STOP;
               ctl_in.action = ACT_STOP;
            end
         end
         TYPE_LIGHT: begin
            if (mode_ff) begin
               ctl_in.action = ACT_FWD;
               level         = band_level(band);
               if (band_ff != {1'b0, band}) begin
                  ctl_in.report_valid   = 1'b1;
                  ctl_in.report_percent = band_percent(band);
               end
               band_in = {1'b0, band};
            end
         end
         default: begin
         end
      endcase
      ctl_in.factor     = FACTOR_W'(level) * FACTOR_STEP + FACTOR_BASE;
      ctl_in.light_mode = mode_in;
      ctl_in.direction  = dir_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= 1'b0;
         dir_ff      <= DIR_STOP;
         band_ff     <= BAND_NONE;
         s1_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            mode_ff <= mode_in;
            dir_ff  <= dir_in;
            band_ff <= band_in;
         end
         if (adv) begin
            s1_valid_ff <= req_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ctl_ff <= ctl_in;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1_ctl   = s1_ctl_ff;

   `FPMC_ASSERT_NEXT(a_key_leaves_light, clock, reset,
      accept && (req_type == TYPE_KEY) && mode_ff,
      !mode_ff && (dir_ff == DIR_STOP), "key in light mode must stop the fan")
   `FPMC_ASSERT_NEXT(a_byte_ignored_light, clock, reset,
      accept && (req_type == TYPE_BYTE) && mode_ff,
      mode_ff && $stable(dir_ff), "byte in light mode must not change state")
   `FPMC_ASSERT_NEXT(a_band_tracks_sample, clock, reset,
      accept && (req_type == TYPE_LIGHT) && mode_ff,
      !band_ff[2] && (band_ff[1:0] == $past(light_sample[11:10])),
      "band memory must follow light sample")

endmodule

>>> rtl/fpmc_scale.sv
// ----------------------------------------------------------------------------
// fpmc_scale
// Duty scaling: period times factor, registered, then exact divide by 100
// through a reciprocal multiply.
// ----------------------------------------------------------------------------
module fpmc_scale import fpmc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic [PERIOD_W-1:0] period,
   input  logic                s1_valid,
   input  fpmc_ctl_type        s1_ctl,
   output logic                s2_valid,
   output fpmc_ctl_type        s2_ctl,
   output logic [PERIOD_W-1:0] quotient
);

   logic               s2_valid_ff;
   fpmc_ctl_type       s2_ctl_ff;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [FULL_W-1:0]  full;

   assign prod_in = PROD_W'(period) * PROD_W'(s1_ctl.factor);
   assign full    = FULL_W'(prod_ff) * FULL_W'(RECIP_MUL);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_ctl_ff <= s1_ctl;
         prod_ff   <= prod_in;
      end
   end

   assign s2_valid = s2_valid_ff;
   assign s2_ctl   = s2_ctl_ff;
   assign quotient = full[RECIP_SH +: PERIOD_W];

endmodule
